/* rtl/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants for the HSV to RGB converter with scaled output.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int FS_W   = 16;
    localparam int OUT_W  = 16;
    localparam int NUM_CH = 3;

    // Chroma and secondary products.
    localparam int SB_W = 2 * PCT_W;
    localparam int XW_W = 6;
    // Channel values on a scale where 600000 is full intensity.
    localparam int CHAN_W = 20;

    localparam int unsigned HUE_WRAP   = 360;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned PCT_MAX    = 100;

    // The full-intensity unit 600000 splits into 2**6 * 9375.
    localparam int UNIT_SHIFT         = 6;
    localparam int unsigned UNIT_ODD  = 9375;
    localparam int MUL_W              = FS_W + CHAN_W;
    localparam int PP_W               = MUL_W - UNIT_SHIFT;

    // Floor reciprocal of UNIT_ODD; the quotient estimate is low by at most one.
    localparam int RECIP_SHIFT = 44;
    localparam int RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd9375);
    localparam int PROD_W = PP_W + RECIP_W;

    localparam logic [FS_W-1:0] FULL_SCALE_RESET = 16'd255;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } hsv_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } rgb_out_t;

    // Lane 0 is red, lane 1 green, lane 2 blue.
    typedef logic [NUM_CH-1:0][CHAN_W-1:0] chan_vals_t;

endpackage

/* rtl/hsv_to_rgb_scaled.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_scaled
// HSV to RGB converter; each channel is scaled to a configured full-scale value.
//
//   Channel  Signals                          Payload
//   hsv      hsv_valid / hsv_ready            hue, saturation, brightness
//   rgb      rgb_valid / rgb_ready            red, green, blue
//   cfg      cfg_valid / cfg_ready            full_scale write data
//
// One color per cycle when the output is taken every cycle. An accepted color
// passes through two front stages, one queue slot, then three back stages for
// the scaling multiply and the reciprocal divide by 600000.
// The queue lets the front keep taking items while the output is stalled.
// Reset loads full_scale with 255 and empties every stage; cfg is always ready.
// ----------------------------------------------------------------------------
module hsv_to_rgb_scaled
#(
    parameter int QUEUE_DEPTH = hsvrgb_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hsv_valid,
    output logic                          hsv_ready,
    input  hsvrgb_pkg::hsv_in_t           hsv,
    output logic                          rgb_valid,
    input  logic                          rgb_ready,
    output hsvrgb_pkg::rgb_out_t          rgb,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hsvrgb_pkg::FS_W-1:0]   cfg_data
);
    import hsvrgb_pkg::*;

    logic [FS_W-1:0] full_scale_reg;
    logic            f_valid;
    logic            f_ready;
    chan_vals_t      f_data;
    logic            q_valid;
    logic            q_ready;
    chan_vals_t      q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_scale_reg <= FULL_SCALE_RESET;
        else if (cfg_valid && cfg_ready)
            full_scale_reg <= cfg_data;
    end

    hsvrgb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready),
        .hsv        (hsv),
        .chan_valid (f_valid),
        .chan_ready (f_ready),
        .chan_vals  (f_data)
    );

    hsvrgb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    hsvrgb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .full_scale (full_scale_reg),
        .chan_valid (q_valid),
        .chan_ready (q_ready),
        .chan_vals  (q_data),
        .rgb_valid  (rgb_valid),
        .rgb_ready  (rgb_ready),
        .rgb        (rgb)
    );

`ifndef NO_ASSERTIONS
    // A queue head that the back end cannot take must still be there next cycle.
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_ready) |=> (q_valid && $stable(q_data)))
        else $error("queue dropped or changed its head while stalled");

    // The front must hold its channel values while the queue is full.
    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && !f_ready) |=> (f_valid && $stable(f_data)))
        else $error("front changed its values while the queue was full");
`endif

endmodule

/* rtl/hsvrgb_front.sv */
// ----------------------------------------------------------------------------
// hsvrgb_front
// Accepts HSV items, clamps them, finds the hue sector and builds the three
// unscaled channel values over two pipeline stages.
// ----------------------------------------------------------------------------
module hsvrgb_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  hsv_valid,
    output logic                  hsv_ready,
    input  hsvrgb_pkg::hsv_in_t   hsv,
    output logic                  chan_valid,
    input  logic                  chan_ready,
    output hsvrgb_pkg::chan_vals_t chan_vals
);
    import hsvrgb_pkg::*;

    logic              s1_vld_reg, s1_vld_next;
    sector_t           sector_reg, sector_next;
    logic [XW_W-1:0]   xw_reg, xw_next;
    logic [SB_W-1:0]   sb_reg, sb_next;
    logic [PCT_W-1:0]  bri_reg, bri_next;

    logic              s2_vld_reg, s2_vld_next;
    chan_vals_t        vals_reg, vals_next;

    logic [HUE_W-1:0]  hue_w;
    logic [HUE_W-1:0]  hue_m;
    logic [XW_W-1:0]   hue_dist;
    logic [PCT_W-1:0]  sat_c;
    logic [PCT_W-1:0]  bri_c;
    logic              s1_load;
    logic              s2_load;
    logic [CHAN_W-1:0] c_val;
    logic [CHAN_W-1:0] x_val;
    logic [CHAN_W-1:0] m_val;
    logic [CHAN_W-1:0] vc;
    logic [CHAN_W-1:0] vx;

    assign s2_load   = s1_vld_reg && (!s2_vld_reg || chan_ready);
    assign hsv_ready = !s1_vld_reg || s2_load;
    assign s1_load   = hsv_valid && hsv_ready;

    // Stage 1: clamp, wrap the hue once, sector and distance from 60, 180 or 300 degrees.
    always_comb
    begin
        sat_c = (hsv.saturation > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : hsv.saturation;
        bri_c = (hsv.brightness > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : hsv.brightness;
        hue_w = (hsv.hue >= HUE_W'(HUE_WRAP)) ? hsv.hue - HUE_W'(HUE_WRAP) : hsv.hue;

        if (hue_w >= HUE_W'(5 * SECTOR_DEG))
            sector_next = SEC_M_R;
        else if (hue_w >= HUE_W'(4 * SECTOR_DEG))
            sector_next = SEC_B_M;
        else if (hue_w >= HUE_W'(3 * SECTOR_DEG))
            sector_next = SEC_C_B;
        else if (hue_w >= HUE_W'(2 * SECTOR_DEG))
            sector_next = SEC_G_C;
        else if (hue_w >= HUE_W'(SECTOR_DEG))
            sector_next = SEC_Y_G;
        else
            sector_next = SEC_R_Y;

        // Hue modulo 120 degrees.
        if (hue_w >= HUE_W'(4 * SECTOR_DEG))
            hue_m = hue_w - HUE_W'(4 * SECTOR_DEG);
        else if (hue_w >= HUE_W'(2 * SECTOR_DEG))
            hue_m = hue_w - HUE_W'(2 * SECTOR_DEG);
        else
            hue_m = hue_w;

        if (hue_m >= HUE_W'(SECTOR_DEG))
            hue_dist = XW_W'(hue_m - HUE_W'(SECTOR_DEG));
        else
            hue_dist = XW_W'(HUE_W'(SECTOR_DEG) - hue_m);

        xw_next     = XW_W'(SECTOR_DEG) - hue_dist;
        sb_next     = SB_W'(sat_c) * SB_W'(bri_c);
        bri_next    = bri_c;
        s1_vld_next = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_vld_reg);
    end

    // Stage 2: chroma, secondary and offset, then placement by sector.
    always_comb
    begin
        c_val = CHAN_W'(sb_reg) * CHAN_W'(SECTOR_DEG);
        x_val = CHAN_W'(sb_reg) * CHAN_W'(xw_reg);
        m_val = (CHAN_W'(bri_reg) * CHAN_W'(PCT_MAX) - CHAN_W'(sb_reg))
                * CHAN_W'(SECTOR_DEG);
        vc = c_val + m_val;
        vx = x_val + m_val;

        case (sector_reg)
            SEC_R_Y: vals_next = {m_val, vx, vc};
            SEC_Y_G: vals_next = {m_val, vc, vx};
            SEC_G_C: vals_next = {vx, vc, m_val};
            SEC_C_B: vals_next = {vc, vx, m_val};
            SEC_B_M: vals_next = {vc, m_val, vx};
            default: vals_next = {vx, m_val, vc};
        endcase

        s2_vld_next = s2_load ? 1'b1 : (chan_ready ? 1'b0 : s2_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            sector_reg <= sector_next;
            xw_reg     <= xw_next;
            sb_reg     <= sb_next;
            bri_reg    <= bri_next;
        end
        if (s2_load)
        begin
            vals_reg <= vals_next;
        end
    end

    assign chan_valid = s2_vld_reg;
    assign chan_vals  = vals_reg;

endmodule

/* rtl/hsvrgb_queue.sv */
// ----------------------------------------------------------------------------
// hsvrgb_queue
// Short first-in first-out queue of channel values between front and back.
// ----------------------------------------------------------------------------
module hsvrgb_queue
#(
    parameter int DEPTH = hsvrgb_pkg::QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_valid,
    output logic                   wr_ready,
    input  hsvrgb_pkg::chan_vals_t wr_data,
    output logic                   rd_valid,
    input  logic                   rd_ready,
    output hsvrgb_pkg::chan_vals_t rd_data
);
    import hsvrgb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    chan_vals_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

/* rtl/hsvrgb_back.sv */
// ----------------------------------------------------------------------------
// hsvrgb_back
// Scales the three channel values by full_scale and divides by the unit
// 600000 with a reciprocal multiply and a one-step correction.
// ----------------------------------------------------------------------------
module hsvrgb_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [hsvrgb_pkg::FS_W-1:0] full_scale,
    input  logic                   chan_valid,
    output logic                   chan_ready,
    input  hsvrgb_pkg::chan_vals_t chan_vals,
    output logic                   rgb_valid,
    input  logic                   rgb_ready,
    output hsvrgb_pkg::rgb_out_t   rgb
);
    import hsvrgb_pkg::*;

    logic              b1_vld_reg, b1_vld_next;
    logic [PP_W-1:0]   b1_pp_reg [NUM_CH];
    logic [PP_W-1:0]   b1_pp_next [NUM_CH];
    logic              b2_vld_reg, b2_vld_next;
    logic [PP_W-1:0]   b2_pp_reg [NUM_CH];
    logic [OUT_W-1:0]  b2_q_reg [NUM_CH];
    logic [OUT_W-1:0]  b2_q_next [NUM_CH];
    logic              out_vld_reg, out_vld_next;
    logic [OUT_W-1:0]  q_next [NUM_CH];
    rgb_out_t          rgb_reg;

    logic [MUL_W-1:0]  scaled [NUM_CH];
    logic [PROD_W-1:0] recip_prod [NUM_CH];
    logic [PP_W-1:0]   remainder [NUM_CH];
    logic              out_space;
    logic              b2_ready;
    logic              b1_load;
    logic              b2_load;
    logic              out_load;

    assign out_space  = !out_vld_reg || rgb_ready;
    assign out_load   = b2_vld_reg && out_space;
    assign b2_ready   = !b2_vld_reg || out_space;
    assign b2_load    = b1_vld_reg && b2_ready;
    assign chan_ready = !b1_vld_reg || b2_ready;
    assign b1_load    = chan_valid && chan_ready;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            // Product over 64 first, the odd factor 9375 is left.
            scaled[i]     = MUL_W'(full_scale) * MUL_W'(chan_vals[i]);
            b1_pp_next[i] = scaled[i][MUL_W-1:UNIT_SHIFT];

            recip_prod[i] = PROD_W'(b1_pp_reg[i]) * PROD_W'(RECIP);
            b2_q_next[i]  = recip_prod[i][RECIP_SHIFT+OUT_W-1:RECIP_SHIFT];

            remainder[i]  = b2_pp_reg[i] - PP_W'(b2_q_reg[i]) * PP_W'(UNIT_ODD);
            q_next[i]     = (remainder[i] >= PP_W'(UNIT_ODD)) ? b2_q_reg[i] + 1'b1
                                                               : b2_q_reg[i];
        end
        b1_vld_next  = b1_load ? 1'b1 : (b2_load ? 1'b0 : b1_vld_reg);
        b2_vld_next  = b2_load ? 1'b1 : (out_load ? 1'b0 : b2_vld_reg);
        out_vld_next = out_load ? 1'b1 : (rgb_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            b1_vld_reg  <= b1_vld_next;
            b2_vld_reg  <= b2_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (b1_load)
                b1_pp_reg[i] <= b1_pp_next[i];
            if (b2_load)
            begin
                b2_pp_reg[i] <= b1_pp_reg[i];
                b2_q_reg[i]  <= b2_q_next[i];
            end
        end
        if (out_load)
        begin
            rgb_reg.red   <= q_next[0];
            rgb_reg.green <= q_next[1];
            rgb_reg.blue  <= q_next[2];
        end
    end

    assign rgb_valid = out_vld_reg;
    assign rgb       = rgb_reg;

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hsv_to_rgb_scaled. Colors go in through the hsv
// channel with random gaps, the rgb channel stalls at random, and every
// result is checked against an integer model of the conversion that tracks
// the full_scale register. Covers the hue sector edges, hue wrap, percent
// saturation, full_scale extremes and a long output stall.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgb_pkg::*;

    localparam longint unsigned FULL_UNIT = 600000;
    localparam int LATENCY_PAD  = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCHDOG_MAX = 5000;

    logic                clk;
    logic                rst_n;
    logic                hsv_valid;
    logic                hsv_ready;
    hsv_in_t             hsv;
    logic                rgb_valid;
    logic                rgb_ready;
    rgb_out_t            rgb;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [FS_W-1:0]     cfg_data;

    rgb_out_t            color_queue[$];
    logic [FS_W-1:0]     full_scale_model;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  failures;
    int                  quiet_cycles;
    int                  hold_left;
    bit                  hold_req;

    hsv_to_rgb_scaled dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic logic [OUT_W-1:0] scale_channel(int unsigned level,
                                                       logic [FS_W-1:0] scale);
        longint unsigned prod;
        prod = scale;
        prod = prod * level;
        return OUT_W'(prod / FULL_UNIT);
    endfunction

    // Channel levels are kept as integers where 600000 is full intensity.
    function automatic rgb_out_t predict_rgb(hsv_in_t c, logic [FS_W-1:0] scale);
        int unsigned h, s, v, hm, hue_dist, chroma, second, offset, r, g, bl;
        rgb_out_t res;
        h = c.hue;
        s = (c.saturation > PCT_MAX) ? PCT_MAX : c.saturation;
        v = (c.brightness > PCT_MAX) ? PCT_MAX : c.brightness;
        if (h >= HUE_WRAP)
            h = h - HUE_WRAP;
        hm = h % (2 * SECTOR_DEG);
        hue_dist = (hm >= SECTOR_DEG) ? (hm - SECTOR_DEG) : (SECTOR_DEG - hm);
        chroma = s * v * SECTOR_DEG;
        second = s * v * (SECTOR_DEG - hue_dist);
        offset = (PCT_MAX * v - s * v) * SECTOR_DEG;
        r = 0;
        g = 0;
        bl = 0;
        case (sector_t'(3'(h / SECTOR_DEG)))
            SEC_R_Y: begin r = chroma; g = second; end
            SEC_Y_G: begin r = second; g = chroma; end
            SEC_G_C: begin g = chroma; bl = second; end
            SEC_C_B: begin g = second; bl = chroma; end
            SEC_B_M: begin r = second; bl = chroma; end
            default: begin r = chroma; bl = second; end
        endcase
        res.red   = scale_channel(r + offset, scale);
        res.green = scale_channel(g + offset, scale);
        res.blue  = scale_channel(bl + offset, scale);
        return res;
    endfunction

    function automatic hsv_in_t random_color();
        hsv_in_t c;
        c.hue = HUE_W'(($urandom_range(9) == 0) ? $urandom_range(511, 361)
                                                : $urandom_range(360));
        c.saturation = PCT_W'(($urandom_range(7) == 0) ? $urandom_range(127, 101)
                                                       : $urandom_range(100));
        c.brightness = PCT_W'(($urandom_range(7) == 0) ? $urandom_range(127, 101)
                                                       : $urandom_range(100));
        return c;
    endfunction

    function automatic hsv_in_t make_color(int h, int s, int v);
        hsv_in_t c;
        c.hue = HUE_W'(h);
        c.saturation = PCT_W'(s);
        c.brightness = PCT_W'(v);
        return c;
    endfunction

    task automatic send_color(hsv_in_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hsv_valid <= 1'b0;
            @(posedge clk);
        end
        hsv <= c;
        hsv_valid <= 1'b1;
        @(posedge clk);
        while (!hsv_ready)
            @(posedge clk);
        color_queue.push_back(predict_rgb(c, full_scale_model));
    endtask

    // Stops offering colors and waits until every expected result is out.
    task automatic settle();
        hsv_valid <= 1'b0;
        while (color_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic write_full_scale(logic [FS_W-1:0] value);
        settle();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        full_scale_model = value;
    endtask

    // Receiver: checks each transfer and drives rgb_ready, including long holds.
    always @(posedge clk)
    begin
        rgb_out_t want;
        if (rgb_valid && rgb_ready)
        begin
            if (color_queue.size() == 0)
            begin
                $error("rgb: result with no expected color pending");
                failures++;
            end
            else
            begin
                want = color_queue.pop_front();
                if (rgb.red !== want.red)
                begin
                    $error("red: expected %0d, actual %0d", want.red, rgb.red);
                    failures++;
                end
                if (rgb.green !== want.green)
                begin
                    $error("green: expected %0d, actual %0d", want.green, rgb.green);
                    failures++;
                end
                if (rgb.blue !== want.blue)
                begin
                    $error("blue: expected %0d, actual %0d", want.blue, rgb.blue);
                    failures++;
                end
            end
        end
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rgb_ready <= 1'b0;
        end
        else
            rgb_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((hsv_valid && hsv_ready) || (rgb_valid && rgb_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Sector edges, hue wrap and percent clamping at the reset full_scale.
    task automatic test_sectors();
        int hues[16] = '{0, 30, 59, 60, 90, 119, 120, 180, 239, 240, 300, 359,
                         360, 361, 420, 511};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (hues[i])
            send_color(make_color(hues[i], 100, 100));
        send_color(make_color(200, 0, 100));
        send_color(make_color(200, 100, 0));
        send_color(make_color(511, 127, 127));
        send_color(make_color(45, 101, 50));
        send_color(make_color(150, 64, 101));
    endtask

    task automatic test_scale_extremes();
        logic [FS_W-1:0] scales[3] = '{16'd0, 16'hFFFF, 16'd1};
        foreach (scales[i])
        begin
            write_full_scale(scales[i]);
            send_color(make_color(0, 100, 100));
            send_color(make_color(100, 37, 83));
            send_color(make_color(333, 127, 127));
            send_color(random_color());
        end
    endtask

    // Output held off long enough that the input must stall behind it.
    task automatic test_output_stall();
        int k;
        write_full_scale(16'($urandom_range(65535)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_req = 1'b1;
        @(posedge clk);
        for (k = 0; k < 40; k++)
            send_color(random_color());
        settle();
    endtask

    task automatic test_random(int tx_idle, int rx_idle, int count);
        int k;
        for (k = 0; k < 4; k++)
        begin
            write_full_scale(16'((k == 0) ? $urandom_range(300) : $urandom_range(65535)));
            send_idle_pct = tx_idle;
            recv_idle_pct = rx_idle;
            repeat (count / 4) send_color(random_color());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        hsv_valid = 1'b0;
        hsv = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rgb_ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        failures = 0;
        quiet_cycles = 0;
        hold_left = 0;
        hold_req = 1'b0;
        full_scale_model = FULL_SCALE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sectors();
        test_scale_extremes();
        test_output_stall();
        test_random(28, 69, 400);
        test_random(69, 28, 400);
        test_random(0, 0, 400);
        settle();

        if (failures == 0 && color_queue.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
